// File: sv/sync_length_frame_receiver_assert.svh
// Assertion macros used by the frame receiver top level.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
// Invariant that holds at every clock edge outside reset.
`define SLFR_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("frame receiver invariant violated");
// Condition in one cycle that implies a consequence in the same cycle.
`define SLFR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver implication violated");
`else
`define SLFR_ASSERT_ALWAYS(label, expr)
`define SLFR_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

// File: sv/slfr_pkg.sv
// Shared types, codes and constants of the sync/length frame receiver.
`default_nettype none
package slfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 12;
    localparam int JOBQ_DEPTH      = 2;

    // Register reset values.
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'h45;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h43;
    localparam logic [15:0] TIMEOUT_RST     = 16'd100;

    // Register indexes.
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_NOMSG = 2'd1;
    localparam logic [1:0] KIND_LED   = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Job codes passed from the front end to the back end.
    localparam logic [1:0] JOB_NOMSG = 2'd0;
    localparam logic [1:0] JOB_TEXT  = 2'd1;
    localparam logic [1:0] JOB_LED   = 2'd2;

    // Frame type and subtype bytes.
    localparam logic [7:0] TYPE_MSG  = 8'h53;
    localparam logic [7:0] SUB_NOMSG = 8'h00;
    localparam logic [7:0] SUB_TEXT  = 8'h01;
    localparam logic [7:0] TYPE_LED  = 8'h0D;
    localparam logic [7:0] SUB_LED   = 8'h0B;

    // Tick counter.
    localparam int              TICK_W   = 17;
    localparam logic [TICK_W-1:0] TICK_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0] job;
        logic       led;
    } job_hdr_t;

endpackage
`default_nettype wire

// File: sv/slfr_front.sv
// Front end: sync hunt, length check, payload capture, timeout and frame classification.
`default_nettype none
module slfr_front #(
    parameter int  MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W       = $clog2(MAX_PAYLOAD)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slfr_pkg::cfg_t     cfg,
    input  wire logic               push,
    input  wire logic               cmd,
    input  wire logic [7:0]         rx_byte,
    output logic                    full,
    output logic                    q_push,
    output slfr_pkg::job_hdr_t      q_hdr,
    output logic [LEN_W-1:0]        q_len,
    input  wire logic               q_full,
    input  wire logic               text_done,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output logic [7:0]              rd_data
);
    import slfr_pkg::*;

    localparam logic [2:0] STAGE_HUNT = 3'd0;
    localparam logic [2:0] STAGE_GOT1 = 3'd1;
    localparam logic [2:0] STAGE_GOT2 = 3'd2;
    localparam logic [2:0] STAGE_LEN  = 3'd3;
    localparam logic [2:0] STAGE_DATA = 3'd4;

    logic [2:0]        stage_reg, stage_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              led_reg, led_next;
    logic [7:0]        h0_reg, h0_next, h1_reg, h1_next, h2_reg, h2_next;
    logic [7:0]        h0_eff, h1_eff, h2_eff;
    logic [1:0]        text_jobs_reg, text_jobs_next;
    logic              accept;
    logic              mem_wr;
    logic [7:0]        mem [MAX_PAYLOAD];
    logic [7:0]        rd_data_reg;

    // Payload bytes may not be overwritten while a text frame is still being read out.
    assign full   = q_full || ((stage_reg == STAGE_DATA) && (text_jobs_reg != 2'd0));
    assign accept = push && !full;

    // Header bytes as seen including the byte arriving now.
    assign h0_eff = (cnt_reg == LEN_W'(0)) ? rx_byte : h0_reg;
    assign h1_eff = (cnt_reg == LEN_W'(1)) ? rx_byte : h1_reg;
    assign h2_eff = (cnt_reg == LEN_W'(2)) ? rx_byte : h2_reg;

    // Hunt state machine and frame classification.
    always_comb
    begin
        stage_next = stage_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        ticks_next = ticks_reg;
        led_next   = led_reg;
        h0_next    = h0_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        mem_wr     = 1'b0;
        q_push     = 1'b0;
        q_hdr.job  = JOB_NOMSG;
        q_len      = len_reg;
        if (accept)
        begin
            if (cmd == CMD_TICK)
            begin
                if (stage_reg == STAGE_DATA)
                begin
                    if (ticks_reg != TICK_MAX)
                    begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                    if (ticks_next > {1'b0, cfg.timeout})
                    begin
                        stage_next = STAGE_HUNT;
                    end
                end
            end
            else
            begin
                unique case (stage_reg)
                    STAGE_HUNT:
                    begin
                        if (rx_byte == cfg.sync_first)
                        begin
                            stage_next = STAGE_GOT1;
                        end
                    end
                    STAGE_GOT1:
                    begin
                        stage_next = (rx_byte == cfg.sync_second) ? STAGE_GOT2 : STAGE_HUNT;
                    end
                    STAGE_GOT2:
                    begin
                        stage_next = (rx_byte == cfg.sync_first) ? STAGE_LEN : STAGE_HUNT;
                    end
                    STAGE_LEN:
                    begin
                        if (rx_byte > 8'(MAX_PAYLOAD))
                        begin
                            stage_next = STAGE_HUNT;
                        end
                        else
                        begin
                            len_next   = rx_byte[LEN_W-1:0];
                            cnt_next   = '0;
                            ticks_next = '0;
                            stage_next = (rx_byte == 8'h00) ? STAGE_HUNT : STAGE_DATA;
                        end
                    end
                    STAGE_DATA:
                    begin
                        mem_wr   = (cnt_reg < LEN_W'(MAX_PAYLOAD));
                        h0_next  = h0_eff;
                        h1_next  = h1_eff;
                        h2_next  = h2_eff;
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_next >= len_reg)
                        begin
                            stage_next = STAGE_HUNT;
                            if (len_reg >= LEN_W'(2))
                            begin
                                if (h0_eff == TYPE_MSG)
                                begin
                                    if (h1_eff == SUB_NOMSG)
                                    begin
                                        q_push    = 1'b1;
                                        q_hdr.job = JOB_NOMSG;
                                    end
                                    else if (h1_eff == SUB_TEXT)
                                    begin
                                        q_push    = 1'b1;
                                        q_hdr.job = JOB_TEXT;
                                    end
                                end
                                else if ((h0_eff == TYPE_LED) && (h1_eff == SUB_LED)
                                         && (len_reg >= LEN_W'(3)))
                                begin
                                    led_next  = (h2_eff != 8'h00);
                                    q_push    = 1'b1;
                                    q_hdr.job = JOB_LED;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        stage_next = STAGE_HUNT;
                    end
                endcase
            end
        end
        q_hdr.led = led_next;
    end

    // Text jobs outstanding in the queue or in the back end.
    always_comb
    begin
        text_jobs_next = text_jobs_reg;
        if (q_push && (q_hdr.job == JOB_TEXT))
        begin
            text_jobs_next = text_jobs_next + 2'd1;
        end
        if (text_done)
        begin
            text_jobs_next = text_jobs_next - 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= STAGE_HUNT;
            len_reg       <= '0;
            cnt_reg       <= '0;
            ticks_reg     <= '0;
            led_reg       <= 1'b0;
            text_jobs_reg <= 2'd0;
        end
        else
        begin
            stage_reg     <= stage_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            ticks_reg     <= ticks_next;
            led_reg       <= led_next;
            text_jobs_reg <= text_jobs_next;
        end
    end

    // Header byte copies used for classification.
    always_ff @(posedge clk)
    begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
        h2_reg <= h2_next;
    end

    // Payload store: written by the hunt logic, read by the back end.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/slfr_jobq.sv
// Short first-word-fall-through queue of frame jobs between front and back end.
`default_nettype none
module slfr_jobq #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = slfr_pkg::JOBQ_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);
    import slfr_pkg::*;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// File: sv/slfr_back.sv
// Back end: turns frame jobs into result items and holds the output register.
`default_nettype none
module slfr_back #(
    parameter int  MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W       = $clog2(MAX_PAYLOAD)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire slfr_pkg::job_hdr_t  q_hdr,
    input  wire logic [LEN_W-1:0]    q_len,
    output logic                     q_pop,
    output logic                     text_done,
    output logic                     rd_en,
    output logic [IDX_W-1:0]         rd_addr,
    input  wire logic [7:0]          rd_data,
    input  wire logic                pop,
    output logic                     empty,
    output logic [1:0]               kind,
    output logic [7:0]               text_char,
    output logic                     led_level,
    output logic                     last
);
    import slfr_pkg::*;

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_ADDR = 2'd1;
    localparam logic [1:0] BK_DATA = 2'd2;
    localparam logic [1:0] BK_END  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             led_reg, led_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_char_reg;
    logic             out_led_reg;
    logic             out_last_reg;
    logic             slot_free;
    logic             load;
    logic [1:0]       ld_kind;
    logic [7:0]       ld_char;
    logic             ld_led;
    logic             ld_last;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || pop;
    assign rd_addr   = idx_reg[IDX_W-1:0];

    // Readout sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        led_next   = led_reg;
        q_pop      = 1'b0;
        text_done  = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        ld_kind    = KIND_NOMSG;
        ld_char    = 8'h00;
        ld_led     = led_reg;
        ld_last    = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_hdr.job == JOB_TEXT)
                    begin
                        q_pop      = 1'b1;
                        len_next   = q_len;
                        led_next   = q_hdr.led;
                        idx_next   = LEN_W'(2);
                        state_next = BK_ADDR;
                    end
                    else if (slot_free)
                    begin
                        q_pop   = 1'b1;
                        load    = 1'b1;
                        ld_kind = (q_hdr.job == JOB_LED) ? KIND_LED : KIND_NOMSG;
                        ld_led  = q_hdr.led;
                    end
                end
            end
            BK_ADDR:
            begin
                if (idx_reg < len_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = BK_DATA;
                end
                else
                begin
                    state_next = BK_END;
                end
            end
            BK_DATA:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    ld_kind    = KIND_TEXT;
                    ld_char    = rd_data;
                    ld_last    = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = BK_ADDR;
                end
            end
            BK_END:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    ld_kind    = KIND_END;
                    text_done  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job context and output payload.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        led_reg <= led_next;
        if (load)
        begin
            out_kind_reg <= ld_kind;
            out_char_reg <= ld_char;
            out_led_reg  <= ld_led;
            out_last_reg <= ld_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign kind      = out_kind_reg;
    assign text_char = out_char_reg;
    assign led_level = out_led_reg;
    assign last      = out_last_reg;

endmodule
`default_nettype wire

// File: sv/sync_length_frame_receiver.sv
// Top level of the sync-header, length-prefixed frame receiver.
// Usage:
//   Input requests (cmd, rx_byte) are offered with push and taken when full is low.
//   cmd low carries one received byte, cmd high one time tick.
//   Results (kind, text_char, led_level, last) wait while empty is low and are
//   taken with pop; last marks the final result caused by one input request.
//   Registers are written over cfg_valid/cfg_index/cfg_data; cfg_ready is always high.
// Timing:
//   An input request is taken in the cycle it is offered while full is low. A frame
//   that completes with a known type queues a job; a notice or LED result moves from
//   the queue into the output register once that register is free. A text frame's
//   job is picked up, then each character is read through the store's registered
//   read port and loaded into the output register, and an end marker follows.
//   The job queue holds two frames; full rises when it is full, or while the front
//   end awaits payload bytes and a text frame is queued or being read from the store.
// Reset:
//   rst_n clears the hunt to its first stage, the LED level to off, the job queue
//   and the output register; registers return to their reset values.
// Stalls:
//   While pop is low the output holds, the back end waits and the queue fills,
//   after which full holds off further input requests.
`default_nettype none
`include "sync_length_frame_receiver_assert.svh"
module sync_length_frame_receiver #(
    parameter int  MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W       = $clog2(MAX_PAYLOAD)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        cmd,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       text_char,
    output logic             led_level,
    output logic             last
);
    import slfr_pkg::*;

    localparam int JOB_W = $bits(job_hdr_t) + LEN_W;

    cfg_t             cfg_reg;
    job_hdr_t         f_hdr, b_hdr;
    logic [LEN_W-1:0] f_len, b_len;
    logic [JOB_W-1:0] q_din, q_dout;
    logic             q_push, q_pop, q_full, q_empty;
    logic             text_done;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.timeout     <= TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data[7:0];
                CFG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data[7:0];
                CFG_TIMEOUT:     cfg_reg.timeout     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Front end.
    slfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .cmd       (cmd),
        .rx_byte   (rx_byte),
        .full      (full),
        .q_push    (q_push),
        .q_hdr     (f_hdr),
        .q_len     (f_len),
        .q_full    (q_full),
        .text_done (text_done),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Job queue.
    assign q_din = {f_hdr, f_len};

    slfr_jobq #(
        .WIDTH (JOB_W),
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign b_hdr = q_dout[JOB_W-1:LEN_W];
    assign b_len = q_dout[LEN_W-1:0];

    // Back end.
    slfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_hdr     (b_hdr),
        .q_len     (b_len),
        .q_pop     (q_pop),
        .text_done (text_done),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .pop       (pop),
        .empty     (empty),
        .kind      (kind),
        .text_char (text_char),
        .led_level (led_level),
        .last      (last)
    );

    // Checks on queue use and on the shape of the results.
    `SLFR_ASSERT_IMPLY(a_full_when_queue_full, q_full, full)
    `SLFR_ASSERT_IMPLY(a_no_pop_when_queue_empty, q_pop, !q_empty)
    `SLFR_ASSERT_ALWAYS(a_char_zero_unless_text, empty || (kind == KIND_TEXT) || (text_char == 8'h00))
    `SLFR_ASSERT_ALWAYS(a_last_matches_kind, empty || (last == (kind != KIND_TEXT)))

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the sync/length frame receiver, with a built-in frame predictor.
`timescale 1ns / 100ps
module tb_top;
    import slfr_pkg::*;

    localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
    localparam int RUN_LIMIT    = 500000;
    localparam int DRAIN_CYCLES = 48;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 80;
    localparam int PRINT_CAP    = 30;

    // The register index that the block ignores.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        GOT_FIRST,
        GOT_SECOND,
        WANT_LENGTH,
        IN_PAYLOAD
    } hunt_stage_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_char;
        logic       led_level;
        logic       last;
    } frame_result_t;

    typedef struct packed {
        logic          req_cmd;
        logic [7:0]    req_byte;
        logic          typed;
        logic          has_result;
        frame_result_t want;
    } stim_row_t;

    localparam frame_result_t NO_RESULT = '0;
    localparam int DIRECTED_COUNT = 28;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_SYNC_FIRST;
    logic [15:0] cfg_data  = '0;
    logic        push      = 1'b0;
    logic        cmd       = CMD_BYTE;
    logic [7:0]  rx_byte   = '0;
    logic        pop       = 1'b0;
    logic        cfg_ready;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  text_char;
    logic        led_level;
    logic        last;

    // Predictor copy of the registers and the deframer state.
    logic [7:0]   first_cfg   = SYNC_FIRST_RST;
    logic [7:0]   second_cfg  = SYNC_SECOND_RST;
    logic [15:0]  timeout_cfg = TIMEOUT_RST;
    hunt_stage_t  stage_now   = HUNT_FIRST;
    logic [3:0]   len_now     = '0;
    logic [3:0]   count_now   = '0;
    logic [7:0]   payload_now [MAX_PAYLOAD];
    logic [16:0]  ticks_seen  = '0;
    logic         led_now     = 1'b0;

    frame_result_t step_out [$];
    frame_result_t pending_results [$];
    stim_row_t     directed_rows [DIRECTED_COUNT];

    int fail_count    = 0;
    int useful_items  = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int hold_requests = 0;
    int send_idle_pct = 0;
    int pop_idle_pct  = 0;
    int idle_levels [3] = '{0, 20, 50};

    sync_length_frame_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .rx_byte   (rx_byte),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .text_char (text_char),
        .led_level (led_level),
        .last      (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Gap lengths: mostly short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advances the deframer by one request and leaves its results in step_out.
    function automatic void deframe_step(input logic c, input logic [7:0] d);
        frame_result_t r;
        step_out.delete();
        if (c == CMD_TICK)
        begin
            // Ticks only count while payload bytes are awaited.
            if (stage_now == IN_PAYLOAD)
            begin
                if (ticks_seen < TICK_MAX)
                    ticks_seen++;
                if (ticks_seen > {1'b0, timeout_cfg})
                    stage_now = HUNT_FIRST;
            end
            return;
        end
        case (stage_now)
            HUNT_FIRST:
                if (d == first_cfg)
                    stage_now = GOT_FIRST;
            GOT_FIRST:
                stage_now = (d == second_cfg) ? GOT_SECOND : HUNT_FIRST;
            GOT_SECOND:
                stage_now = (d == first_cfg) ? WANT_LENGTH : HUNT_FIRST;
            WANT_LENGTH:
                if (d > MAX_PAYLOAD)
                    stage_now = HUNT_FIRST;
                else
                begin
                    len_now    = d[3:0];
                    count_now  = '0;
                    ticks_seen = '0;
                    stage_now  = (d == 8'h00) ? HUNT_FIRST : IN_PAYLOAD;
                end
            default:
            begin
                if (count_now < MAX_PAYLOAD)
                    payload_now[count_now] = d;
                count_now++;
                if (count_now >= len_now)
                begin
                    stage_now = HUNT_FIRST;
                    // Frame complete: decode by type and subtype.
                    if (len_now >= 2 && payload_now[0] == TYPE_MSG)
                    begin
                        if (payload_now[1] == SUB_NOMSG)
                        begin
                            r = '{KIND_NOMSG, 8'h00, 1'b0, 1'b0};
                            step_out.push_back(r);
                        end
                        else if (payload_now[1] == SUB_TEXT)
                        begin
                            for (int i = 2; i < len_now; i++)
                            begin
                                r = '{KIND_TEXT, payload_now[i], 1'b0, 1'b0};
                                step_out.push_back(r);
                            end
                            r = '{KIND_END, 8'h00, 1'b0, 1'b0};
                            step_out.push_back(r);
                        end
                    end
                    else if (len_now >= 3 && payload_now[0] == TYPE_LED &&
                             payload_now[1] == SUB_LED)
                    begin
                        led_now = (payload_now[2] != 8'h00);
                        r = '{KIND_LED, 8'h00, 1'b0, 1'b0};
                        step_out.push_back(r);
                    end
                end
            end
        endcase
        // Every result carries the LED level after the step; the final one is marked.
        foreach (step_out[k])
            step_out[k].led_level = led_now;
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    // Offers one request and waits until the block takes it.
    task automatic send_item(input logic c, input logic [7:0] d, input logic predicted);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = pick_gap();
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        cmd     <= c;
        rx_byte <= d;
        do
            @(posedge clk);
        while (full);
        if (!(c == CMD_TICK && stage_now != IN_PAYLOAD))
            useful_items++;
        deframe_step(c, d);
        if (predicted)
            foreach (step_out[i])
                pending_results.push_back(step_out[i]);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SYNC_FIRST:  first_cfg   = value[7:0];
            CFG_SYNC_SECOND: second_cfg  = value[7:0];
            CFG_TIMEOUT:     timeout_cfg = value;
            default:         ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] first, input logic [7:0] second,
                                  input logic [15:0] ticks_allowed);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        // Upper data bits must be masked off by the sync registers.
        write_register(CFG_SYNC_FIRST, {junk, first});
        write_register(CFG_SYNC_SECOND, {~junk, second});
        write_register(CFG_TIMEOUT, ticks_allowed);
        write_register(CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Waits until every expected result has arrived and the back end has gone quiet.
    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One random sequence: mostly well-formed frames, some noise and broken headers.
    task automatic send_sequence();
        logic [7:0] body [MAX_PAYLOAD];
        int         pick;
        int         sel;
        int         len;
        int         cut;
        logic       timed_out;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 6))
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
            return;
        end
        send_item(CMD_BYTE, first_cfg, 1'b1);
        // Header broken at the second or the third byte.
        if (pick < 18)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(CMD_BYTE, second_cfg, 1'b1);
                send_item(CMD_BYTE, first_cfg ^ 8'($urandom_range(1, 255)), 1'b1);
            end
            else
                send_item(CMD_BYTE, second_cfg ^ 8'($urandom_range(1, 255)), 1'b1);
            repeat ($urandom_range(0, 3))
                send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            return;
        end
        send_item(CMD_BYTE, second_cfg, 1'b1);
        send_item(CMD_BYTE, first_cfg, 1'b1);
        // Length byte of zero or over the limit.
        if (pick < 26)
        begin
            if ($urandom_range(0, 1) == 1)
                send_item(CMD_BYTE, 8'h00, 1'b1);
            else
                send_item(CMD_BYTE, 8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b1);
            repeat ($urandom_range(0, 2))
                send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            return;
        end
        foreach (body[i])
            body[i] = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        if (sel <= 2)
        begin
            len     = $urandom_range(2, MAX_PAYLOAD);
            body[0] = TYPE_MSG;
            body[1] = SUB_TEXT;
        end
        else if (sel == 3)
        begin
            len     = $urandom_range(2, 5);
            body[0] = TYPE_MSG;
            body[1] = SUB_NOMSG;
        end
        else if (sel <= 5)
        begin
            len     = $urandom_range(3, 6);
            body[0] = TYPE_LED;
            body[1] = SUB_LED;
            if ($urandom_range(0, 1) == 1)
                body[2] = 8'h00;
        end
        else if (sel == 6)
        begin
            // Frames of one or two bytes with a message or LED type byte.
            len     = $urandom_range(1, 2);
            body[0] = ($urandom_range(0, 1) == 1) ? TYPE_MSG : TYPE_LED;
            body[1] = ($urandom_range(0, 1) == 1) ? SUB_TEXT : SUB_LED;
        end
        else
        begin
            len = $urandom_range(0, MAX_PAYLOAD);
            if ($urandom_range(0, 99) < 30)
                body[0] = ($urandom_range(0, 1) == 1) ? TYPE_MSG : TYPE_LED;
        end
        timed_out = (pick >= 88) && (timeout_cfg <= 40) && (len > 0);
        cut = timed_out ? $urandom_range(0, len - 1) : -1;
        send_item(CMD_BYTE, 8'(len), 1'b1);
        for (int i = 0; i < len; i++)
        begin
            if (i == cut)
                repeat (timeout_cfg + 1 + $urandom_range(0, 2))
                    send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
            else if ($urandom_range(0, 99) < 8)
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
            send_item(CMD_BYTE, body[i], 1'b1);
        end
    endtask

    // Result side: checks each accepted result and drives pop with random stalls.
    initial
    begin : result_side
        frame_result_t got;
        frame_result_t want;
        int            stall_left;
        int            served;
        stall_left = 0;
        served     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got = '{kind, text_char, led_level, last};
                if (pending_results.size() == 0)
                    report_mismatch("arrived with nothing expected, kind", got.kind, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.text_char != want.text_char)
                        report_mismatch("text_char", got.text_char, want.text_char);
                    if (got.led_level != want.led_level)
                        report_mismatch("led_level", got.led_level, want.led_level);
                    if (got.last != want.last)
                        report_mismatch("last", got.last, want.last);
                end
                results_seen++;
            end
            // A long hold-off lets the block fill up and push back on the sender.
            if (served != hold_requests)
            begin
                served     = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < pop_idle_pct)
            begin
                pop <= 1'b0;
                stall_left = pick_gap() - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("sync_length_frame_receiver verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int         phase;
        int         target;
        logic [7:0] twin;
        // Directed requests under the reset settings; typed rows carry their own answer.
        directed_rows = '{
            '{CMD_TICK, 8'h00, 1'b1, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h43, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h02, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h53, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h00, 1'b1, 1'b1, '{KIND_NOMSG, 8'h00, 1'b0, 1'b1}},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h43, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h03, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h0D, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h0B, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'hFF, 1'b1, 1'b1, '{KIND_LED, 8'h00, 1'b1, 1'b1}},
            '{CMD_BYTE, 8'h45, 1'b1, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b1, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h43, 1'b1, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h43, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h0D, 1'b1, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h43, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h45, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h03, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h53, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'h01, 1'b0, 1'b0, NO_RESULT},
            '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, NO_RESULT}
        };
        foreach (payload_now[i])
            payload_now[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        pop_idle_pct  = 30;
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].req_cmd, directed_rows[i].req_byte,
                      !directed_rows[i].typed);
            if (directed_rows[i].typed && directed_rows[i].has_result)
                pending_results.push_back(directed_rows[i].want);
        end

        // Random phases, each under its own register settings.
        for (phase = 0; phase < 5; phase++)
        begin
            settle();
            twin = 8'($urandom_range(0, 255));
            case (phase)
                0: apply_settings(8'h00, 8'hFF, 16'd1);
                1: apply_settings(8'hFF, 8'h00, 16'hFFFF);
                2: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  16'($urandom_range(2, 40)));
                3: apply_settings(twin, twin, 16'($urandom_range(5, 30)));
                default: apply_settings(SYNC_FIRST_RST, SYNC_SECOND_RST, 16'd12);
            endcase
            if (phase == 1 || phase == 3)
                hold_requests++;
            target = useful_items + PHASE_ITEMS;
            while (useful_items < target)
            begin
                send_idle_pct = idle_levels[$urandom_range(0, 2)];
                pop_idle_pct  = idle_levels[$urandom_range(0, 2)];
                send_sequence();
            end
        end

        settle();
        if (fail_count == 0)
            $display("sync_length_frame_receiver verification clean");
        else
            $display("sync_length_frame_receiver verification failed");
        $finish;
    end

endmodule

// File: sync_length_frame_receiver.f
+incdir+sv
sv/slfr_pkg.sv
sv/slfr_front.sv
sv/slfr_jobq.sv
sv/slfr_back.sv
sv/sync_length_frame_receiver.sv
verif/tb_top.sv
